// File: rtl/asa_pkg.sv
// ----------------------------------------------------------------------------
// asa_pkg
// Shared types and codes of the aligned stack allocator: operation and
// status codes, the entry memory word and the result record.
// ----------------------------------------------------------------------------
package asa_pkg;

    localparam int PAD_W = 15;

    typedef enum logic [1:0] {
        FUNC_PUSH    = 2'd0,
        FUNC_POP     = 2'd1,
        FUNC_POP_N   = 2'd2,
        FUNC_DEALLOC = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_FIT     = 3'd1,
        ST_UNDERFLOW  = 3'd2,
        ST_MISMATCH   = 3'd3,
        ST_STORE_FULL = 3'd4
    } status_t;

    // register indexes on the configuration port
    localparam logic REG_BUFFER_BASE = 1'b0;
    localparam logic REG_BUFFER_SIZE = 1'b1;

    // one stack entry; the unaligned start is kept as the padding in front
    typedef struct packed {
        logic [31:0]      addr;
        logic [31:0]      bytes;
        logic [PAD_W-1:0] pad;
    } entry_t;

    // packed so that the last field sits in the lowest bits
    typedef struct packed {
        logic [6:0]  entry_total;
        logic [31:0] top_size;
        logic [31:0] top_address;
        logic        is_full;
        logic        is_empty;
        logic [31:0] bytes_allocated;
        logic [31:0] bytes_remaining;
        logic [2:0]  status;
        logic [31:0] granted_address;
    } result_t;

endpackage

// File: rtl/asa_entry_ram.sv
// ----------------------------------------------------------------------------
// asa_entry_ram
// Entry storage of the stack: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module asa_entry_ram #(
    parameter int DEPTH = 64,
    parameter int IW    = 6
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [IW-1:0]   wr_idx,
    input  asa_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [IW-1:0]   rd_idx,
    output asa_pkg::entry_t rd_data
);

    asa_pkg::entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_idx];
        end
    end

endmodule

// File: rtl/asa_apb_regs.sv
// ----------------------------------------------------------------------------
// asa_apb_regs
// Configuration registers behind an APB-style port: buffer base and size.
// ----------------------------------------------------------------------------
module asa_apb_regs (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] buffer_base,
    output logic [31:0] buffer_size
);

    logic [31:0] base_reg;
    logic [31:0] size_reg;
    logic        wr_stb;

    assign pready = 1'b1;
    assign wr_stb = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            size_reg <= '0;
        end else if (wr_stb) begin
            unique case (paddr[2])
                asa_pkg::REG_BUFFER_BASE: base_reg <= pwdata;
                asa_pkg::REG_BUFFER_SIZE: size_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            asa_pkg::REG_BUFFER_BASE: prdata = base_reg;
            asa_pkg::REG_BUFFER_SIZE: prdata = size_reg;
            default:                  prdata = '0;
        endcase
    end

    assign buffer_base = base_reg;
    assign buffer_size = size_reg;

endmodule

// File: rtl/asa_engine.sv
// ----------------------------------------------------------------------------
// asa_engine
// Operation sequencer: keeps the top entry in registers, writes pushes to
// the entry memory and reloads the top from it after each release that leaves entries.
// ----------------------------------------------------------------------------
module asa_engine #(
    parameter int MAX_ENTRIES = 64,
    parameter int IW          = 6,
    parameter int LW          = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [31:0]      buffer_base,
    input  logic [31:0]      buffer_size,
    // request
    input  logic             req_valid,
    output logic             req_ready,
    input  logic [1:0]       req_func,
    input  logic [31:0]      req_size,
    input  logic [3:0]       req_align_log2,
    input  logic [6:0]       req_pop_count,
    input  logic [31:0]      req_free_address,
    // result
    output logic             res_valid,
    input  logic             res_ready,
    output asa_pkg::result_t res_data,
    // entry memory
    output logic             mem_wr_en,
    output logic [IW-1:0]    mem_wr_idx,
    output asa_pkg::entry_t  mem_wr_data,
    output logic             mem_rd_en,
    output logic [IW-1:0]    mem_rd_idx,
    input  asa_pkg::entry_t  mem_rd_data
);

    localparam int CW = (LW > 7) ? LW : 7;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_LOAD = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       func_reg;
    logic [31:0]      size_reg;
    logic [3:0]       lg_reg;
    logic [6:0]       cnt_reg;
    logic [31:0]      faddr_reg;
    logic [LW-1:0]    live_reg;
    logic [31:0]      used_reg;
    asa_pkg::entry_t  top_reg;
    logic [31:0]      granted_reg;
    logic [2:0]       status_reg;
    asa_pkg::result_t out_reg;
    logic             out_valid_reg;

    logic [31:0]              free_bytes;
    logic [31:0]              cur;
    logic [15:0]              mask16;
    logic [asa_pkg::PAD_W-1:0] pad;
    logic [32:0]              need;
    logic                     fits;
    logic [31:0]              aligned;
    logic [32:0]              span;
    logic [31:0]              used_released;
    logic [LW-1:0]            live_dec;
    logic [LW-1:0]            live_dec2;
    logic                     out_free;
    logic                     accept;
    logic                     emit;
    logic                     do_release;
    logic                     do_push;
    logic [2:0]               status_exec;
    logic [31:0]              rem;
    logic [LW+6:0]            live_ext;

    assign free_bytes = (buffer_size > used_reg) ? (buffer_size - used_reg) : 32'd0;

    // push arithmetic
    assign cur    = (live_reg == '0) ? buffer_base : (top_reg.addr + top_reg.bytes);
    assign mask16 = (16'd1 << lg_reg) - 16'd1;
    assign pad    = (asa_pkg::PAD_W'(0) - cur[asa_pkg::PAD_W-1:0])
                  & mask16[asa_pkg::PAD_W-1:0];
    assign need   = {{(33-asa_pkg::PAD_W){1'b0}}, pad} + {1'b0, size_reg};
    assign fits   = need <= {1'b0, free_bytes};
    assign aligned = cur + {{(32-asa_pkg::PAD_W){1'b0}}, pad};

    // release arithmetic
    assign span = {1'b0, top_reg.bytes} + {{(33-asa_pkg::PAD_W){1'b0}}, top_reg.pad};
    assign used_released = (span >= {1'b0, used_reg}) ? 32'd0 : (used_reg - span[31:0]);
    assign live_dec  = live_reg - LW'(1);
    assign live_dec2 = live_dec - LW'(1);

    assign out_free  = !out_valid_reg || res_ready;
    assign req_ready = (state_reg == S_IDLE) || ((state_reg == S_EMIT) && out_free);
    assign accept    = req_valid && req_ready;
    assign emit      = (state_reg == S_EMIT) && out_free;

    // decide what the execute cycle does
    always_comb begin
        do_release  = 1'b0;
        do_push     = 1'b0;
        status_exec = status_reg;
        unique case (func_reg)
            asa_pkg::FUNC_PUSH: begin
                if (live_reg >= LW'(MAX_ENTRIES)) begin
                    status_exec = asa_pkg::ST_STORE_FULL;
                end else if (!fits) begin
                    status_exec = asa_pkg::ST_NO_FIT;
                end else begin
                    status_exec = asa_pkg::ST_OK;
                    do_push     = 1'b1;
                end
            end
            asa_pkg::FUNC_POP: begin
                if (live_reg == '0) begin
                    status_exec = asa_pkg::ST_UNDERFLOW;
                end else begin
                    do_release = 1'b1;
                end
            end
            asa_pkg::FUNC_POP_N: begin
                // the comparison keeps its outcome as count and depth drop together
                status_exec = (CW'(cnt_reg) > CW'(live_reg)) ? asa_pkg::ST_UNDERFLOW
                                                             : asa_pkg::ST_OK;
                do_release  = (cnt_reg != '0) && (live_reg != '0);
            end
            asa_pkg::FUNC_DEALLOC: begin
                if (live_reg == '0) begin
                    status_exec = asa_pkg::ST_UNDERFLOW;
                end else if (top_reg.addr != faddr_reg) begin
                    status_exec = asa_pkg::ST_MISMATCH;
                end else begin
                    do_release = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) state_next = S_EXEC;
            end
            S_EXEC: begin
                if (do_release && (live_dec != '0)) begin
                    state_next = S_LOAD;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_LOAD: begin
                state_next = (func_reg == asa_pkg::FUNC_POP_N) ? S_EXEC : S_EMIT;
            end
            S_EMIT: begin
                if (out_free) state_next = accept ? S_EXEC : S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // memory accesses
    assign mem_wr_en   = (state_reg == S_EXEC) && do_push;
    assign mem_wr_idx  = live_reg[IW-1:0];
    assign mem_wr_data = '{addr: aligned, bytes: size_reg, pad: pad};
    assign mem_rd_en   = (state_reg == S_EXEC) && do_release && (live_dec != '0);
    assign mem_rd_idx  = live_dec2[IW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            live_reg      <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_EXEC) begin
                if (do_push) begin
                    live_reg <= live_reg + LW'(1);
                    used_reg <= used_reg + need[31:0];
                end else if (do_release) begin
                    live_reg <= live_dec;
                    used_reg <= used_released;
                end
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rem      = free_bytes;
    assign live_ext = {7'd0, live_reg};

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg    <= req_func;
            size_reg    <= req_size;
            lg_reg      <= req_align_log2;
            cnt_reg     <= req_pop_count;
            faddr_reg   <= req_free_address;
            granted_reg <= '0;
            status_reg  <= asa_pkg::ST_OK;
        end else if (state_reg == S_EXEC) begin
            status_reg <= status_exec;
            if (do_push) begin
                granted_reg <= aligned;
                top_reg     <= mem_wr_data;
            end
            if (do_release && (func_reg == asa_pkg::FUNC_POP_N)) begin
                cnt_reg <= cnt_reg - 7'd1;
            end
        end else if (state_reg == S_LOAD) begin
            top_reg <= mem_rd_data;
        end
        if (emit) begin
            out_reg.granted_address <= granted_reg;
            out_reg.status          <= status_reg;
            out_reg.bytes_remaining <= rem;
            out_reg.bytes_allocated <= buffer_size - rem;
            out_reg.is_empty        <= (rem == buffer_size);
            out_reg.is_full         <= (rem == 32'd0);
            out_reg.top_address     <= (live_reg != '0) ? top_reg.addr : 32'd0;
            out_reg.top_size        <= (live_reg != '0) ? top_reg.bytes : 32'd0;
            out_reg.entry_total     <= live_ext[6:0];
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

endmodule

// File: rtl/aligned_stack_allocator.sv
// ----------------------------------------------------------------------------
// aligned_stack_allocator
// LIFO allocator over one buffer with power-of-two aligned pushes.
// ----------------------------------------------------------------------------
// Each request is one of push, pop, pop count or deallocate by address, and
// gives exactly one result transfer with the grant, a status code, the byte
// counters and the current top entry. Every entry sits in a one-read,
// one-write memory of MAX_ENTRIES words with a registered read, and
// the top entry is mirrored in registers; nothing in the memory is cleared
// after reset, since only entries written by their push are ever read. A push,
// a request that fails and a pop or deallocate that empties the stack go
// from the execute state straight to the emit state; a pop or deallocate
// that leaves entries passes through a load state that reloads the new top
// from the memory. A pop count alternates the execute and load states,
// one memory read per release that leaves entries behind. The next
// request is taken in the cycle the result is loaded into the output
// register; write buffer_base (offset 0) and buffer_size (offset 4) only
// while no request is in flight.
module aligned_stack_allocator #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // requests
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // request_size, align_log2, pop_count, free_address
    input  logic [1:0]   s_tuser,   // func
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [175:0] m_tdata    // granted_address, status, bytes_remaining,
                                    // bytes_allocated, is_empty, is_full,
                                    // top_address, top_size, entry_total
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LW = $clog2(MAX_ENTRIES + 1);

    logic [31:0]      buffer_base;
    logic [31:0]      buffer_size;
    asa_pkg::result_t res_data;
    logic             mem_wr_en;
    logic [IW-1:0]    mem_wr_idx;
    asa_pkg::entry_t  mem_wr_data;
    logic             mem_rd_en;
    logic [IW-1:0]    mem_rd_idx;
    asa_pkg::entry_t  mem_rd_data;

    asa_apb_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .buffer_base (buffer_base),
        .buffer_size (buffer_size)
    );

    asa_entry_ram #(
        .DEPTH (MAX_ENTRIES),
        .IW    (IW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_idx  (mem_wr_idx),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_idx  (mem_rd_idx),
        .rd_data (mem_rd_data)
    );

    asa_engine #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IW          (IW),
        .LW          (LW)
    ) u_engine (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .buffer_base      (buffer_base),
        .buffer_size      (buffer_size),
        .req_valid        (s_tvalid),
        .req_ready        (s_tready),
        .req_func         (s_tuser),
        .req_size         (s_tdata[31:0]),
        .req_align_log2   (s_tdata[35:32]),
        .req_pop_count    (s_tdata[42:36]),
        .req_free_address (s_tdata[74:43]),
        .res_valid        (m_tvalid),
        .res_ready        (m_tready),
        .res_data         (res_data),
        .mem_wr_en        (mem_wr_en),
        .mem_wr_idx       (mem_wr_idx),
        .mem_wr_data      (mem_wr_data),
        .mem_rd_en        (mem_rd_en),
        .mem_rd_idx       (mem_rd_idx),
        .mem_rd_data      (mem_rd_data)
    );

    // pad the result record up to whole bytes
    assign m_tdata = {4'd0, res_data};

endmodule
